>>> rtl/core/ctgr_pkg.sv
package ctgr_pkg;

   // glyph cell geometry
   localparam int GLYPH_ROWS = 5;
   localparam int GLYPH_COLS = 3;
   localparam int GLYPH_BITS = GLYPH_ROWS * GLYPH_COLS;
   localparam logic [15:0] ADVANCE = 16'd4;

   // queue between front and back
   localparam int QDEPTH = 2;
   localparam int QPTR_W = $clog2(QDEPTH);

   // register indexes
   localparam logic [2:0] CSR_ORIGIN_X    = 3'd0;
   localparam logic [2:0] CSR_ORIGIN_Y    = 3'd1;
   localparam logic [2:0] CSR_CLIP_LEFT   = 3'd2;
   localparam logic [2:0] CSR_CLIP_TOP    = 3'd3;
   localparam logic [2:0] CSR_CLIP_WIDTH  = 3'd4;
   localparam logic [2:0] CSR_CLIP_HEIGHT = 3'd5;
   localparam logic [2:0] CSR_INK_COLOR   = 3'd6;

   // register reset values
   localparam logic [7:0]  CLIP_SIZE_RESET = 8'd255;
   localparam logic [15:0] INK_RESET       = 16'hFFFF;

   typedef struct packed {
      logic [15:0] origin_x;
      logic [15:0] origin_y;
      logic [15:0] clip_left;
      logic [15:0] clip_top;
      logic [7:0]  clip_width;
      logic [7:0]  clip_height;
      logic [15:0] ink_color;
   } cfg_type;

   // one character for the back end: clipped pixel mask, bit r*3+c, and its cursor x
   typedef struct packed {
      logic [GLYPH_BITS-1:0] mask;
      logic [15:0]           cx;
   } job_type;

endpackage

>>> rtl/core/ctgr_front.sv
module ctgr_front import ctgr_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   input  logic [7:0]  req_text_byte,
   input  logic        req_first,
   input  logic        q_full,
   input  cfg_type     cfg,
   output logic        q_push,
   output job_type     q_data
);

   localparam logic [7:0] SPACE = 8'h20;

   // two-byte sequences to base letters, anything else to space
   function automatic logic [7:0] pair_code(input logic [7:0] lead, input logic [7:0] n);
      logic [7:0] code;
      code = SPACE;
      case (lead)
         8'hC3: begin
            if (n inside {8'hB3, 8'h93}) code = "O";
         end
         8'hC4: begin
            if (n inside {8'h85, 8'h84}) code = "A";
            else if (n inside {8'h87, 8'h86}) code = "C";
            else if (n inside {8'h99, 8'h98}) code = "E";
         end
         8'hC5: begin
            if (n inside {8'h82, 8'h81}) code = "L";
            else if (n inside {8'h84, 8'h83}) code = "N";
            else if (n inside {8'h9B, 8'h9A}) code = "S";
            else if (n inside {8'hBA, 8'hB9, 8'hBC, 8'hBB}) code = "Z";
         end
         default: code = SPACE;
      endcase
      return code;
   endfunction

   // font: one octal digit per row, top row first, MSB is the left column
   function automatic logic [14:0] glyph_rows(input logic [7:0] raw);
      logic [7:0]  code;
      logic [14:0] g;
      code = raw;
      if (raw inside {[8'h61:8'h7A]}) code = raw - 8'd32;
      case (code)
         "A": g = 15'o25755;  "B": g = 15'o65656;  "C": g = 15'o34443;
         "D": g = 15'o65556;  "E": g = 15'o74647;  "F": g = 15'o74644;
         "G": g = 15'o34553;  "H": g = 15'o55755;  "I": g = 15'o72227;
         "J": g = 15'o11152;  "K": g = 15'o55655;  "L": g = 15'o44447;
         "M": g = 15'o57755;  "N": g = 15'o57775;  "O": g = 15'o25552;
         "P": g = 15'o65644;  "Q": g = 15'o25573;  "R": g = 15'o65655;
         "S": g = 15'o34216;  "T": g = 15'o72222;  "U": g = 15'o55557;
         "V": g = 15'o55552;  "W": g = 15'o55775;  "X": g = 15'o55255;
         "Y": g = 15'o55222;  "Z": g = 15'o71247;
         "0": g = 15'o75557;  "1": g = 15'o26227;  "2": g = 15'o61247;
         "3": g = 15'o61216;  "4": g = 15'o55711;  "5": g = 15'o74616;
         "6": g = 15'o34652;  "7": g = 15'o71222;  "8": g = 15'o25252;
         "9": g = 15'o25316;
         "!": g = 15'o22202;  ".": g = 15'o00002;  ",": g = 15'o00024;
         ":": g = 15'o02020;  "?": g = 15'o61202;  "/": g = 15'o11244;
         8'h27: g = 15'o22000;
         "-": g = 15'o00700;
         default: g = 15'o00000;
      endcase
      return g;
   endfunction

   logic [15:0] cursor_ff, cursor_in;
   logic [7:0]  lead_ff, lead_in;
   logic        pend_ff, pend_in;
   logic        stop_ff, stop_in;

   logic              accept;
   logic [15:0]       cx;
   logic              pend_eff, stop_eff;
   logic              complete;
   logic [7:0]        code;
   logic [14:0]       rows;
   logic signed [16:0] cx17, lim17;
   logic              stop_hit, far_left;
   logic [15:0]       right, bottom, py, px;
   logic [GLYPH_ROWS-1:0] row_ok;
   logic [GLYPH_COLS-1:0] col_ok;
   logic [GLYPH_BITS-1:0] mask;

   assign accept = push && !q_full;

   // string state seen by this byte
   always_comb begin
      cx       = req_first ? cfg.origin_x : cursor_ff;
      pend_eff = req_first ? 1'b0 : pend_ff;
      stop_eff = req_first ? 1'b0 : stop_ff;
   end

   // classify: stopped, lead byte, pair completion or plain code
   always_comb begin
      cursor_in = cx;
      lead_in   = lead_ff;
      pend_in   = pend_eff;
      stop_in   = stop_eff;
      complete  = 1'b0;
      code      = req_text_byte;
      if (!stop_eff) begin
         if (pend_eff) begin
            code     = pair_code(lead_ff, req_text_byte);
            pend_in  = 1'b0;
            complete = 1'b1;
         end else if (req_text_byte[7]) begin
            lead_in = req_text_byte;
            pend_in = 1'b1;
         end else begin
            complete = 1'b1;
         end
      end
      cx17     = {cx[15], cx};
      lim17    = {cfg.clip_left[15], cfg.clip_left} + {9'd0, cfg.clip_width};
      stop_hit = cx17 > lim17;
      far_left = (cx17 + 17'sd3) < $signed({cfg.clip_left[15], cfg.clip_left});
      if (complete) begin
         if (stop_hit) stop_in = 1'b1;
         else cursor_in = cx + ADVANCE;
      end
   end

   // clip window against the 3x5 cell
   always_comb begin
      rows   = glyph_rows(code);
      right  = cfg.clip_left + {8'd0, cfg.clip_width};
      bottom = cfg.clip_top + {8'd0, cfg.clip_height};
      py     = '0;
      px     = '0;
      for (int r = 0; r < GLYPH_ROWS; r++) begin
         py = cfg.origin_y + 16'(r);
         row_ok[r] = ($signed(py) >= $signed(cfg.clip_top)) && ($signed(py) < $signed(bottom));
      end
      for (int c = 0; c < GLYPH_COLS; c++) begin
         px = cx + 16'(c);
         col_ok[c] = ($signed(px) >= $signed(cfg.clip_left)) && ($signed(px) < $signed(right));
      end
      for (int r = 0; r < GLYPH_ROWS; r++) begin
         for (int c = 0; c < GLYPH_COLS; c++) begin
            mask[r*GLYPH_COLS+c] = rows[GLYPH_BITS-1-r*GLYPH_COLS-c] && row_ok[r] && col_ok[c];
         end
      end
   end

   assign q_data.mask = mask;
   assign q_data.cx   = cx;
   assign q_push      = accept && complete && !stop_hit && !far_left && (mask != '0);

   // string state
   always_ff @(posedge clock) begin
      if (reset) begin
         cursor_ff <= '0;
         lead_ff   <= '0;
         pend_ff   <= 1'b0;
         stop_ff   <= 1'b0;
      end else if (accept) begin
         cursor_ff <= cursor_in;
         lead_ff   <= lead_in;
         pend_ff   <= pend_in;
         stop_ff   <= stop_in;
      end
   end

endmodule

>>> rtl/core/ctgr_queue.sv
module ctgr_queue import ctgr_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    wr_en,
   input  job_type wr_data,
   input  logic    rd_en,
   output job_type rd_data,
   output logic    nonempty,
   output logic    full
);

   job_type             slot_ff [QDEPTH];
   logic [QPTR_W-1:0]   wptr_ff, wptr_in;
   logic [QPTR_W-1:0]   rptr_ff, rptr_in;
   logic [QPTR_W:0]     count_ff, count_in;

   assign nonempty = count_ff != '0;
   assign full     = count_ff == (QPTR_W+1)'(QDEPTH);
   assign rd_data  = slot_ff[rptr_ff];

   // pointer and fill count
   always_comb begin
      wptr_in  = wptr_ff;
      rptr_in  = rptr_ff;
      count_in = count_ff;
      if (wr_en) begin
         wptr_in = (wptr_ff == QPTR_W'(QDEPTH - 1)) ? '0 : wptr_ff + 1'b1;
      end
      if (rd_en) begin
         rptr_in = (rptr_ff == QPTR_W'(QDEPTH - 1)) ? '0 : rptr_ff + 1'b1;
      end
      if (wr_en && !rd_en) count_in = count_ff + 1'b1;
      else if (rd_en && !wr_en) count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= '0;
         rptr_ff  <= '0;
         count_ff <= '0;
      end else begin
         wptr_ff  <= wptr_in;
         rptr_ff  <= rptr_in;
         count_ff <= count_in;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (wr_en) slot_ff[wptr_ff] <= wr_data;
   end

endmodule

>>> rtl/core/ctgr_back.sv
module ctgr_back import ctgr_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  cfg_type     cfg,
   input  logic        q_nonempty,
   input  job_type     q_head,
   output logic        q_pop,
   input  logic        pop,
   output logic        empty,
   output logic [15:0] rsp_pixel_x,
   output logic [15:0] rsp_pixel_y,
   output logic [15:0] rsp_pixel_color,
   output logic        rsp_last
);

   logic [GLYPH_BITS-1:0] mask_ff, mask_in;
   logic [15:0]           cx_ff, cx_in;
   logic                  busy_ff, busy_in;
   logic                  out_valid_ff, out_valid_in;
   logic [15:0]           px_ff, px_in;
   logic [15:0]           py_ff, py_in;
   logic [15:0]           color_ff, color_in;
   logic                  last_ff, last_in;

   logic                  advance, done;
   logic [GLYPH_BITS-1:0] low, rest;
   logic [2:0]            row;
   logic [1:0]            col;

   assign advance = busy_ff && (!out_valid_ff || pop);

   // lowest lit pixel of the current character
   always_comb begin
      low  = mask_ff & (~mask_ff + 1'b1);
      rest = mask_ff & ~low;
      done = rest == '0;
      row  = '0;
      col  = '0;
      for (int r = 0; r < GLYPH_ROWS; r++) begin
         for (int c = 0; c < GLYPH_COLS; c++) begin
            if (low[r*GLYPH_COLS+c]) begin
               row = 3'(r);
               col = 2'(c);
            end
         end
      end
   end

   // working character: step through its mask, load the next without a gap
   always_comb begin
      mask_in = mask_ff;
      cx_in   = cx_ff;
      busy_in = busy_ff;
      q_pop   = 1'b0;
      if (advance) begin
         mask_in = rest;
         if (done) busy_in = 1'b0;
      end
      if ((!busy_ff || (advance && done)) && q_nonempty) begin
         q_pop   = 1'b1;
         mask_in = q_head.mask;
         cx_in   = q_head.cx;
         busy_in = 1'b1;
      end
   end

   // output register
   always_comb begin
      out_valid_in = out_valid_ff && !pop;
      px_in        = px_ff;
      py_in        = py_ff;
      color_in     = color_ff;
      last_in      = last_ff;
      if (advance) begin
         out_valid_in = 1'b1;
         px_in        = cx_ff + {14'd0, col};
         py_in        = cfg.origin_y + {13'd0, row};
         color_in     = cfg.ink_color;
         last_in      = done;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      mask_ff  <= mask_in;
      cx_ff    <= cx_in;
      px_ff    <= px_in;
      py_ff    <= py_in;
      color_ff <= color_in;
      last_ff  <= last_in;
   end

   assign empty           = !out_valid_ff;
   assign rsp_pixel_x     = px_ff;
   assign rsp_pixel_y     = py_ff;
   assign rsp_pixel_color = color_ff;
   assign rsp_last        = last_ff;

endmodule

>>> rtl/core/clipped_text_glyph_rasterizer.sv
// A character's first pixel goes from the edge that takes its byte through the queue slot,
// the back end's working character register and the output register to the result ports.
// The back end puts out one pixel per cycle while results are popped, so a character with n lit
// pixels gives n results (at most 15); bytes that draw nothing never reach the queue.
// Reset (synchronous, active high) clears the queue, the output and the string state, and
// returns the configuration registers to their reset values.
module clipped_text_glyph_rasterizer import ctgr_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   output logic        full,
   input  logic [7:0]  req_text_byte,
   input  logic        req_first,
   output logic        empty,
   input  logic        pop,
   output logic [15:0] rsp_pixel_x,
   output logic [15:0] rsp_pixel_y,
   output logic [15:0] rsp_pixel_color,
   output logic        rsp_last,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [15:0] csr_data
);

   cfg_type cfg_ff, cfg_in;
   logic    q_push, q_pop, q_nonempty;
   job_type q_wdata, q_head;

   assign csr_ready = 1'b1;

   // configuration registers
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_ORIGIN_X:    cfg_in.origin_x    = csr_data;
            CSR_ORIGIN_Y:    cfg_in.origin_y    = csr_data;
            CSR_CLIP_LEFT:   cfg_in.clip_left   = csr_data;
            CSR_CLIP_TOP:    cfg_in.clip_top    = csr_data;
            CSR_CLIP_WIDTH:  cfg_in.clip_width  = csr_data[7:0];
            CSR_CLIP_HEIGHT: cfg_in.clip_height = csr_data[7:0];
            CSR_INK_COLOR:   cfg_in.ink_color   = csr_data;
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.origin_x    <= '0;
         cfg_ff.origin_y    <= '0;
         cfg_ff.clip_left   <= '0;
         cfg_ff.clip_top    <= '0;
         cfg_ff.clip_width  <= CLIP_SIZE_RESET;
         cfg_ff.clip_height <= CLIP_SIZE_RESET;
         cfg_ff.ink_color   <= INK_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   ctgr_front u_front (
      .clock         (clock),
      .reset         (reset),
      .push          (push),
      .req_text_byte (req_text_byte),
      .req_first     (req_first),
      .q_full        (full),
      .cfg           (cfg_ff),
      .q_push        (q_push),
      .q_data        (q_wdata)
   );

   ctgr_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (q_push),
      .wr_data  (q_wdata),
      .rd_en    (q_pop),
      .rd_data  (q_head),
      .nonempty (q_nonempty),
      .full     (full)
   );

   ctgr_back u_back (
      .clock           (clock),
      .reset           (reset),
      .cfg             (cfg_ff),
      .q_nonempty      (q_nonempty),
      .q_head          (q_head),
      .q_pop           (q_pop),
      .pop             (pop),
      .empty           (empty),
      .rsp_pixel_x     (rsp_pixel_x),
      .rsp_pixel_y     (rsp_pixel_y),
      .rsp_pixel_color (rsp_pixel_color),
      .rsp_last        (rsp_last)
   );

endmodule

>>> rtl/core/ctgr_checker.sv
module ctgr_checker import ctgr_pkg::*; (
   input logic        clock,
   input logic        reset,
   input logic        full,
   input logic        empty,
   input logic        pop,
   input logic [15:0] rsp_pixel_x,
   input logic [15:0] rsp_pixel_y,
   input logic [15:0] rsp_pixel_color,
   input logic        rsp_last,
   input logic        csr_valid,
   input logic        csr_ready,
   input logic [2:0]  csr_index,
   input logic [15:0] csr_data
);

   logic [15:0] ink_ff, ink_in;
   logic [15:0] left_ff, left_in;

   // shadow copies of the ink color and left clip edge
   always_comb begin
      ink_in  = ink_ff;
      left_in = left_ff;
      if (csr_valid && csr_ready && (csr_index == CSR_INK_COLOR)) ink_in = csr_data;
      if (csr_valid && csr_ready && (csr_index == CSR_CLIP_LEFT)) left_in = csr_data;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ink_ff  <= INK_RESET;
         left_ff <= '0;
      end else begin
         ink_ff  <= ink_in;
         left_ff <= left_in;
      end
   end

   // nothing pending right after reset
   a_reset_idle: assert property (@(posedge clock) reset |=> empty && !full)
      else $error("results or backpressure right after reset");

   // a waiting result holds until taken
   a_hold: assert property (@(posedge clock) disable iff (reset)
      !empty && !pop |=> !empty && $stable(rsp_pixel_x) && $stable(rsp_pixel_y) && $stable(rsp_last))
      else $error("waiting result changed before pop");

   // every pixel carries the programmed ink
   a_color: assert property (@(posedge clock) disable iff (reset)
      !empty |-> rsp_pixel_color == ink_ff)
      else $error("pixel color differs from ink color");

   // no pixel left of the clip edge
   a_clip_left: assert property (@(posedge clock) disable iff (reset)
      !empty |-> $signed(rsp_pixel_x) >= $signed(left_ff))
      else $error("pixel left of clip rectangle");

endmodule

bind clipped_text_glyph_rasterizer ctgr_checker u_checker (.*);
